/* src/beahr_pkg.sv */
// Shared types, constants and helpers of the band envelope attack/hold/release unit.
package beahr_pkg;

    // Default number of tracked bands
    localparam int NUM_BANDS_DEF = 128;

    // Level constants in 1/64 dB units
    localparam logic signed [17:0] ATTACK_STEP = 18'sd384;   // 6 dB
    localparam logic signed [16:0] HYSTERESIS  = 17'sd192;   // 3 dB
    localparam logic signed [15:0] FLOOR_LEVEL = -16'sd8960; // -140 dB
    localparam logic [16:0]        COEF_ONE    = 17'd65536;

    // Register reset values
    localparam logic [16:0]        RELEASE_SLOW_RST = 17'd1700;
    localparam logic [16:0]        RELEASE_FAST_RST = 17'd6600;
    localparam logic [7:0]         HOLD_COUNT_RST   = 8'd4;
    localparam logic signed [15:0] CAL_OFFSET_RST   = 16'sd0;

    // Configuration bus widths
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register index (byte address bits [3:2])
    typedef enum logic [1:0] {
        REG_RELEASE_SLOW = 2'd0,
        REG_RELEASE_FAST = 2'd1,
        REG_HOLD_COUNT   = 2'd2,
        REG_CAL_OFFSET   = 2'd3
    } t_reg_idx;

    // Input item
    typedef struct packed {
        logic [6:0]         band;
        logic signed [15:0] power_db;
        logic signed [15:0] crest_db;
    } t_in;

    // Result item
    typedef struct packed {
        logic [6:0]         band_out;
        logic signed [15:0] tracked_level;
        logic signed [15:0] mean_level;
        logic               fast_release;
    } t_out;

    // Configuration bundle, coefficients already limited to 1.0
    typedef struct packed {
        logic [16:0]        a_slow;
        logic [16:0]        a_fast;
        logic [7:0]         hold_count;
        logic signed [15:0] cal_offset;
    } t_cfg;

    // One band's state word
    typedef struct packed {
        logic signed [15:0] level;
        logic signed [15:0] mean;
        logic               fast_sel;
        logic [7:0]         hold;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RST = '{
        level:    FLOOR_LEVEL,
        mean:     FLOOR_LEVEL,
        fast_sel: 1'b1,
        hold:     8'd0
    };

    // Address bits for a memory of the given depth
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Saturate a 20-bit signed sum to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sd32767;
        end else if (v < -20'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* src/beahr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module beahr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [beahr_pkg::addr_bits(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [beahr_pkg::addr_bits(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    import beahr_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/beahr_regs.sv */
// Configuration register file behind the APB-style port.
module beahr_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [beahr_pkg::PADDR_W-1:0]     paddr,
    input  logic [beahr_pkg::PDATA_W-1:0]     pwdata,
    output logic [beahr_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    output beahr_pkg::t_cfg                   o_cfg
);
    import beahr_pkg::*;

    logic [16:0]        r_release_slow;
    logic [16:0]        r_release_fast;
    logic [7:0]         r_hold_count;
    logic signed [15:0] r_cal_offset;
    t_reg_idx           reg_idx;
    logic               wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_slow <= RELEASE_SLOW_RST;
            r_release_fast <= RELEASE_FAST_RST;
            r_hold_count   <= HOLD_COUNT_RST;
            r_cal_offset   <= CAL_OFFSET_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RELEASE_SLOW: r_release_slow <= pwdata[16:0];
                REG_RELEASE_FAST: r_release_fast <= pwdata[16:0];
                REG_HOLD_COUNT:   r_hold_count   <= pwdata[7:0];
                REG_CAL_OFFSET:   r_cal_offset   <= pwdata[15:0];
                default:          r_hold_count   <= r_hold_count;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_RELEASE_SLOW: prdata = PDATA_W'(r_release_slow);
            REG_RELEASE_FAST: prdata = PDATA_W'(r_release_fast);
            REG_HOLD_COUNT:   prdata = PDATA_W'(r_hold_count);
            REG_CAL_OFFSET:   prdata = PDATA_W'(r_cal_offset);
            default:          prdata = '0;
        endcase
    end

    // Limit coefficients to 1.0
    always_comb begin
        o_cfg.a_slow     = (r_release_slow > COEF_ONE) ? COEF_ONE : r_release_slow;
        o_cfg.a_fast     = (r_release_fast > COEF_ONE) ? COEF_ONE : r_release_fast;
        o_cfg.hold_count = r_hold_count;
        o_cfg.cal_offset = r_cal_offset;
    end

endmodule

/* src/beahr_engine.sv */
// Sequencer and datapath: read a band's state word, update mean and level, write back.
module beahr_engine #(
    parameter int NUM_BANDS = beahr_pkg::NUM_BANDS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  beahr_pkg::t_in                              i_item,
    input  beahr_pkg::t_cfg                             i_cfg,
    output logic                                        o_res_valid,
    output beahr_pkg::t_out                             o_res,
    input  logic                                        i_out_free,
    output logic                                        o_ram_we,
    output logic [beahr_pkg::addr_bits(NUM_BANDS)-1:0]  o_ram_waddr,
    output beahr_pkg::t_entry                           o_ram_wdata,
    output logic [beahr_pkg::addr_bits(NUM_BANDS)-1:0]  o_ram_raddr,
    input  beahr_pkg::t_entry                           i_ram_rdata
);
    import beahr_pkg::*;

    localparam int AW = addr_bits(NUM_BANDS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_MN    = 6'b001000,
        S_LV    = 6'b010000,
        S_WR    = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_addr;
    logic [6:0]         r_band;
    logic               r_inrange;
    logic signed [15:0] r_x;
    logic signed [15:0] r_crest;
    logic               r_fwd;
    t_entry             r_fwd_entry;
    t_entry             r_ent;
    logic signed [34:0] r_mprod;
    logic signed [15:0] r_mn;
    logic               r_rise;
    logic               r_attack;
    logic signed [34:0] r_lprod;
    logic               r_sel_new;
    logic [7:0]         r_hold_new;

    logic               accept;
    logic               wr_go;
    logic [AW+6:0]      band_wide;
    logic [AW-1:0]      in_addr;
    logic               in_range;
    t_entry             rd_ent;
    logic signed [16:0] m_diff;
    logic signed [34:0] m_prod;
    logic signed [16:0] l_diff;
    logic [16:0]        l_coef;
    logic signed [34:0] l_prod;
    logic               sel_new;
    logic [7:0]         hold_new;
    logic               hold_path;
    logic signed [15:0] level_new;
    t_entry             wr_entry;

    // Handshake
    assign wr_go   = (r_state == S_WR) && i_out_free;
    assign o_stall = !((r_state == S_IDLE) || wr_go);
    assign accept  = i_valid && !o_stall;

    // Band to memory address
    assign band_wide = {{AW{1'b0}}, i_item.band};
    assign in_addr   = band_wide[AW-1:0];
    assign in_range  = (11'(i_item.band) < 11'(NUM_BANDS));

    // Take the just-written word when the same band follows directly
    assign rd_ent = r_fwd ? r_fwd_entry : i_ram_rdata;

    // Mean relax product
    assign m_diff = 17'(r_x) - 17'(rd_ent.mean);
    assign m_prod = $signed({1'b0, i_cfg.a_slow}) * m_diff;

    // Release select and coefficient for the level step
    assign hold_path = !r_rise && (r_ent.hold != 8'd0);
    always_comb begin
        sel_new  = r_ent.fast_sel;
        hold_new = r_ent.hold;
        if (r_rise) begin
            if (r_attack) begin
                sel_new  = 1'b1;
                hold_new = i_cfg.hold_count;
            end
        end else if (hold_path) begin
            hold_new = r_ent.hold - 8'd1;
        end else if (17'(r_ent.level) < 17'(r_mn) + HYSTERESIS) begin
            sel_new = 1'b0;
        end
    end
    assign l_coef = (r_rise || sel_new) ? i_cfg.a_fast : i_cfg.a_slow;
    assign l_diff = 17'(r_x) - 17'(r_ent.level);
    assign l_prod = $signed({1'b0, l_coef}) * l_diff;

    // New level
    always_comb begin
        priority if (r_rise && r_attack) begin
            level_new = sat16(20'(r_x) + 20'(r_crest));
        end else if (hold_path) begin
            level_new = r_ent.level;
        end else begin
            level_new = sat16(20'(r_ent.level) + 20'($signed(r_lprod[34:16])));
        end
    end

    assign wr_entry = '{
        level:    level_new,
        mean:     r_mn,
        fast_sel: r_sel_new,
        hold:     r_hold_new
    };

    // Memory ports: clearing sweep or write-back
    assign o_ram_we    = (r_state == S_CLEAR) || (wr_go && r_inrange);
    assign o_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign o_ram_wdata = (r_state == S_CLEAR) ? ENTRY_RST : wr_entry;
    assign o_ram_raddr = in_addr;

    // Result
    assign o_res_valid = wr_go;
    always_comb begin
        o_res.band_out = r_band;
        if (r_inrange) begin
            o_res.tracked_level = level_new;
            o_res.mean_level    = r_mn;
            o_res.fast_release  = r_sel_new;
        end else begin
            o_res.tracked_level = '0;
            o_res.mean_level    = '0;
            o_res.fast_release  = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(NUM_BANDS - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_RD;
            S_RD:    n_state = S_MN;
            S_MN:    n_state = S_LV;
            S_LV:    n_state = S_WR;
            S_WR: begin
                if (accept) begin
                    n_state = S_RD;
                end else if (wr_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (accept) begin
                r_fwd <= o_ram_we && (r_state == S_WR) && (r_addr == in_addr);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr      <= in_addr;
            r_band      <= i_item.band;
            r_inrange   <= in_range;
            r_x         <= sat16(20'(i_item.power_db) - 20'(i_cfg.cal_offset));
            r_crest     <= i_item.crest_db;
            r_fwd_entry <= wr_entry;
        end
        if (r_state == S_RD) begin
            r_ent    <= rd_ent;
            r_mprod  <= m_prod;
            r_rise   <= r_x > rd_ent.level;
            r_attack <= (18'(r_x) + 18'(r_crest)) > (18'(rd_ent.level) + ATTACK_STEP);
        end
        if (r_state == S_MN) begin
            r_mn <= sat16(20'(r_ent.mean) + 20'($signed(r_mprod[34:16])));
        end
        if (r_state == S_LV) begin
            r_lprod    <= l_prod;
            r_sel_new  <= sel_new;
            r_hold_new <= hold_new;
        end
    end

    // Checks
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD))
        else $error("accepted item did not start a read");

    a_fwd_after_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_RD) && r_fwd |-> $past(o_ram_we && (r_state == S_WR)))
        else $error("forwarding without a write-back");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && (r_state == S_WR)) |-> r_inrange)
        else $error("state written for an out-of-range band");

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result offered while output register is full");

endmodule

/* src/band_envelope_attack_hold_release_unit.sv */
// Top level of the per-band attack/hold/release level tracker.
//
//  channel  direction  handshake                    payload
//  input    in         i_in_valid / o_in_stall      i_in_data   (t_in)
//  output   out        o_out_valid / i_out_stall    o_out_data  (t_out)
//  config   in/out     psel penable pwrite pready   paddr pwdata prdata
//
// An item passes through the steps accept (read issued), mean product, mean
// sum, level product and write-back; an item that follows directly is
// accepted during the write-back of the one before. The steps form the one
// read-modify-write of the band state memory; a same-band follower takes
// the written word by forwarding. After reset a clearing pass writes all
// NUM_BANDS entries, with input stalled. A stalled output holds write-back.
module band_envelope_attack_hold_release_unit #(
    parameter int NUM_BANDS = beahr_pkg::NUM_BANDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  beahr_pkg::t_in                    i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output beahr_pkg::t_out                   o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [beahr_pkg::PADDR_W-1:0]     paddr,
    input  logic [beahr_pkg::PDATA_W-1:0]     pwdata,
    output logic [beahr_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);
    import beahr_pkg::*;

    localparam int AW = addr_bits(NUM_BANDS);

    t_cfg          cfg;
    logic          res_valid;
    t_out          res;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;
    logic          r_out_valid;
    t_out          r_out;

    beahr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    beahr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BANDS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    beahr_engine #(
        .NUM_BANDS (NUM_BANDS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_data),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_out_free  (out_free),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Output register: free when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
